// ----- hw/rtl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon test block.
// Used by pip_seg_mem, pip_mul and point_in_polygon_test; depends on nothing.
package pip_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;

   localparam int MAX_SEGMENTS_DEFAULT = 1024;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] X_LIMIT   = 32'sd1800000000;
   localparam logic signed [COORD_W-1:0] Y_LIMIT   = 32'sd900000000;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] ax;
   } seg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD,
      ST_QCHECK,
      ST_QREAD,
      ST_QDIFF,
      ST_QMUL1,
      ST_QMUL2,
      ST_QCMP,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/point_in_polygon_test.sv -----
// Top level of the point-in-polygon test: sequencer, segment table and box.
// Depends on pip_pkg, pip_seg_mem and pip_mul.
//
// Usage: each request word carries an opcode in req_tuser (clear, load
// segment, query point) and the segment endpoints and query point in
// req_tdata. Every request returns exactly one response word on rsp_ with
// inside_res and status. A clear or a load passes through its own state
// and then ST_DONE, which loads the output register once it is free and
// returns to ST_IDLE, where the next word can be taken. A query first
// checks the point against the valid coordinate range and the bounding
// box, then walks the stored segments one after the other: one that does
// not straddle the point's y takes ST_QREAD and ST_QDIFF, one that does
// also takes ST_QMUL1, ST_QMUL2 and ST_QCMP through the shared multiplier.
// The walk stops early when the point equals a stored endpoint. One
// request is worked on at a time and req_tready is low while it runs. The
// response sits in an output register, so the next request may be
// accepted while it waits; a stalled receiver holds the second response
// back until the first is taken.
// Reset empties the table and the box; stored segments are not cleared.
module point_in_polygon_test #(
   parameter int MAX_SEGMENTS = pip_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: seg_ax, seg_ay, seg_bx, seg_by, point_x, point_y (from bit 0 up)
   input  logic [191:0] req_tdata,
   // tuser: opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: inside_res, status, then zero padding (from bit 0 up)
   output logic [7:0]   rsp_tdata
);

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int CRD = pip_pkg::COORD_W;
   localparam int DW  = pip_pkg::DIFF_W;
   localparam int PW  = pip_pkg::PROD_W;

   pip_pkg::state_type state_ff, state_in;

   pip_pkg::seg_type        seg_ff, seg_in;
   logic signed [CRD-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [CRD-1:0]   min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [CRD-1:0]   min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [CW-1:0]           count_ff, count_in, idx_ff, idx_in;
   logic signed [DW-1:0]    tx_ff, tx_in, ty_ff, ty_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PW-1:0]    p1_ff, p1_in;
   logic                    parity_ff, parity_in;
   logic                    res_inside_ff, res_inside_in;
   logic                    res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    table_full;
   logic                    mem_wr_en;
   logic                    mul_second;
   logic                    out_load;
   pip_pkg::seg_type        rd_seg;
   pip_pkg::seg_type        req_seg;
   logic signed [CRD-1:0]   req_px, req_py;
   logic signed [DW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    prod;
   logic [CW-1:0]           idx_next;
   logic                    last_seg;
   logic                    point_ok;
   logic                    endpoint_hit;
   logic                    straddle;
   logic                    flip;

   assign req_seg = req_tdata[127:0];
   assign req_px  = req_tdata[159:128];
   assign req_py  = req_tdata[191:160];

   assign accept     = req_tvalid && req_tready;
   assign table_full = (count_ff == CW'(MAX_SEGMENTS));
   assign idx_next   = idx_ff + 1'b1;
   assign last_seg   = (idx_next == count_ff);

   assign point_ok = (px_ff >= -pip_pkg::X_LIMIT) && (px_ff <= pip_pkg::X_LIMIT) &&
                     (py_ff >= -pip_pkg::Y_LIMIT) && (py_ff <= pip_pkg::Y_LIMIT) &&
                     (px_ff >= min_x_ff) && (px_ff <= max_x_ff) &&
                     (py_ff >= min_y_ff) && (py_ff <= max_y_ff);

   assign endpoint_hit = ((rd_seg.ax == px_ff) && (rd_seg.ay == py_ff)) ||
                         ((rd_seg.bx == px_ff) && (rd_seg.by == py_ff));
   assign straddle     = (rd_seg.by > py_ff) != (rd_seg.ay > py_ff);

   // The side test is tx*dy < dx*ty; dy > 0 decides which way it must go.
   assign flip = ((dy_ff > 0) == (p1_ff < prod));

   pip_seg_mem #(
      .DEPTH (MAX_SEGMENTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (seg_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_seg)
   );

   assign mul_a = mul_second ? dx_ff : tx_ff;
   assign mul_b = mul_second ? ty_ff : dy_ff;

   pip_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  pip_pkg::OP_CLEAR: state_in = pip_pkg::ST_CLEAR;
                  pip_pkg::OP_LOAD:  state_in = pip_pkg::ST_LOAD;
                  pip_pkg::OP_QUERY: state_in = pip_pkg::ST_QCHECK;
                  default:           state_in = pip_pkg::ST_DONE;
               endcase
            end
         end
         pip_pkg::ST_CLEAR: state_in = pip_pkg::ST_DONE;
         pip_pkg::ST_LOAD:  state_in = pip_pkg::ST_DONE;
         pip_pkg::ST_QCHECK: begin
            if (point_ok && (count_ff != '0)) begin
               state_in = pip_pkg::ST_QREAD;
            end else begin
               state_in = pip_pkg::ST_DONE;
            end
         end
         pip_pkg::ST_QREAD: state_in = pip_pkg::ST_QDIFF;
         pip_pkg::ST_QDIFF: begin
            if (endpoint_hit) begin
               state_in = pip_pkg::ST_DONE;
            end else if (straddle) begin
               state_in = pip_pkg::ST_QMUL1;
            end else if (last_seg) begin
               state_in = pip_pkg::ST_DONE;
            end else begin
               state_in = pip_pkg::ST_QREAD;
            end
         end
         pip_pkg::ST_QMUL1: state_in = pip_pkg::ST_QMUL2;
         pip_pkg::ST_QMUL2: state_in = pip_pkg::ST_QCMP;
         pip_pkg::ST_QCMP: begin
            state_in = last_seg ? pip_pkg::ST_DONE : pip_pkg::ST_QREAD;
         end
         pip_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = pip_pkg::ST_IDLE;
            end
         end
         default: state_in = pip_pkg::ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready = 1'b0;
      mem_wr_en  = 1'b0;
      mul_second = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         pip_pkg::ST_IDLE:  req_tready = 1'b1;
         pip_pkg::ST_LOAD:  mem_wr_en  = !table_full;
         pip_pkg::ST_QMUL2: mul_second = 1'b1;
         pip_pkg::ST_DONE:  out_load   = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   // Datapath.
   always_comb begin
      seg_in        = seg_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      min_x_in      = min_x_ff;
      max_x_in      = max_x_ff;
      min_y_in      = min_y_ff;
      max_y_in      = max_y_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      p1_in         = p1_ff;
      parity_in     = parity_ff;
      res_inside_in = res_inside_ff;
      res_status_in = res_status_ff;

      if (accept) begin
         seg_in        = req_seg;
         px_in         = req_px;
         py_in         = req_py;
         res_inside_in = 1'b0;
         res_status_in = 1'b0;
      end

      case (state_ff)
         pip_pkg::ST_CLEAR: begin
            count_in = '0;
            min_x_in = pip_pkg::COORD_MAX;
            min_y_in = pip_pkg::COORD_MAX;
            max_x_in = pip_pkg::COORD_MIN;
            max_y_in = pip_pkg::COORD_MIN;
         end
         pip_pkg::ST_LOAD: begin
            if (table_full) begin
               res_status_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               if (seg_ff.ax < min_x_in) min_x_in = seg_ff.ax;
               if (seg_ff.bx < min_x_in) min_x_in = seg_ff.bx;
               if (seg_ff.ax > max_x_in) max_x_in = seg_ff.ax;
               if (seg_ff.bx > max_x_in) max_x_in = seg_ff.bx;
               if (seg_ff.ay < min_y_in) min_y_in = seg_ff.ay;
               if (seg_ff.by < min_y_in) min_y_in = seg_ff.by;
               if (seg_ff.ay > max_y_in) max_y_in = seg_ff.ay;
               if (seg_ff.by > max_y_in) max_y_in = seg_ff.by;
            end
         end
         pip_pkg::ST_QCHECK: begin
            idx_in    = '0;
            parity_in = 1'b0;
         end
         pip_pkg::ST_QDIFF: begin
            dx_in = {rd_seg.ax[CRD-1], rd_seg.ax} - {rd_seg.bx[CRD-1], rd_seg.bx};
            dy_in = {rd_seg.ay[CRD-1], rd_seg.ay} - {rd_seg.by[CRD-1], rd_seg.by};
            tx_in = {px_ff[CRD-1], px_ff} - {rd_seg.bx[CRD-1], rd_seg.bx};
            ty_in = {py_ff[CRD-1], py_ff} - {rd_seg.by[CRD-1], rd_seg.by};
            if (endpoint_hit) begin
               res_inside_in = 1'b1;
            end else if (!straddle) begin
               idx_in = idx_next;
               if (last_seg) begin
                  res_inside_in = parity_ff;
               end
            end
         end
         pip_pkg::ST_QMUL2: begin
            p1_in = prod;
         end
         pip_pkg::ST_QCMP: begin
            parity_in = parity_ff ^ flip;
            idx_in    = idx_next;
            if (last_seg) begin
               res_inside_in = parity_ff ^ flip;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: a new word is loaded only once the previous one is gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_status_ff, res_inside_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pip_pkg::ST_IDLE;
         count_ff     <= '0;
         min_x_ff     <= pip_pkg::COORD_MAX;
         min_y_ff     <= pip_pkg::COORD_MAX;
         max_x_ff     <= pip_pkg::COORD_MIN;
         max_y_ff     <= pip_pkg::COORD_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff        <= seg_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      idx_ff        <= idx_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      p1_ff         <= p1_in;
      parity_ff     <= parity_in;
      res_inside_ff <= res_inside_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   // The table never holds more segments than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count beyond table depth");

   // The walk only reads entries that were loaded.
   a_idx_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_QREAD |-> idx_ff < count_ff)
      else $error("query walk reads past the loaded segments");

   // The second product is always preceded by the first.
   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_QMUL1 |=> state_ff == pip_pkg::ST_QMUL2)
      else $error("multiplier sequence broken");

   // A load into a full table keeps the count and reports the drop.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pip_pkg::ST_LOAD) && table_full |=>
         (count_ff == CW'(MAX_SEGMENTS)) && res_status_ff)
      else $error("load into a full table not flagged");

   // A clear empties the table.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_CLEAR |=> count_ff == '0)
      else $error("clear left segments in the table");

endmodule

// ----- hw/rtl/pip_seg_mem.sv -----
// Segment table: one write port and one registered read port.
// Depends on pip_pkg for the segment word type.
module pip_seg_mem #(
   parameter int DEPTH = pip_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  pip_pkg::seg_type           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output pip_pkg::seg_type           rd_data
);

   pip_pkg::seg_type mem [DEPTH];
   pip_pkg::seg_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pip_mul.sv -----
// Shared signed multiplier with a registered product, used twice per straddling segment
// for the two halves of the cross-product side test. Depends on pip_pkg.
module pip_mul (
   input  logic                               clock,
   input  logic signed [pip_pkg::DIFF_W-1:0]  op_a,
   input  logic signed [pip_pkg::DIFF_W-1:0]  op_b,
   output logic signed [pip_pkg::PROD_W-1:0]  prod
);

   logic signed [pip_pkg::PROD_W-1:0] prod_ff;
   logic signed [pip_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = pip_pkg::PROD_W'(op_a) * pip_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
